/* rtl/ttcw_pkg.sv */
// Package for the text terminal character writer.
// Holds the request and result structs and the character and request codes.
// No dependencies.
`default_nettype none

package ttcw_pkg;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [7:0]  char_code;
		logic [10:0] cell_index;
	} req_t;

	typedef struct packed {
		logic [15:0] read_data;
		logic [4:0]  cursor_row;
		logic [6:0]  cursor_col;
		logic        scrolled;
	} rsp_t;

	localparam logic [1:0] REQ_PUT   = 2'd0;
	localparam logic [1:0] REQ_CLEAR = 2'd1;
	localparam logic [1:0] REQ_READ  = 2'd2;

	localparam logic [7:0] CH_BACKSPACE = 8'h08;
	localparam logic [7:0] CH_TAB       = 8'h09;
	localparam logic [7:0] CH_NEWLINE   = 8'h0A;
	localparam logic [7:0] CH_RETURN    = 8'h0D;
	localparam logic [7:0] CH_BLANK     = 8'h20;

	localparam logic [7:0]  RESET_COLOR = 8'h0F;
	localparam logic [15:0] RESET_CELL  = 16'h0F20;
	localparam int          TAB_STEP    = 4;

endpackage

`default_nettype wire

/* rtl/ttcw_screen_ram.sv */
// Screen cell store: one write port and one read port with registered read data.
// Standalone; instantiated by the terminal core.
`default_nettype none

module ttcw_screen_ram #(
	parameter int DEPTH  = 2000,
	parameter int ADDR_W = 11
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [15:0]       wdata,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [15:0]       rdata
);

	logic [15:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

/* rtl/text_terminal_char_writer_core.sv */
// Top level of the text terminal character writer: cursor, sequencer and screen store.
// Depends on ttcw_pkg and ttcw_screen_ram.
`default_nettype none

// A request is taken when start is high and busy is low. Every request gives one result,
// shown on result for exactly one cycle while done is high; the receiver cannot stall it.
// A put that does not scroll and a request of the unused type leave the block idle, so such
// requests may follow back to back. A read passes through ST_READ because of the registered
// read of the screen store. In a put that scrolls the store is copied up one row, one cell per
// cycle through its one read port and one write port, and the bottom row is blanked. A clear
// blanks every cell of the store. After reset the block blanks the store in one pass with
// busy high; cfg_we writes the text color at any time.
module text_terminal_char_writer_core #(
	parameter int SCREEN_COLUMNS = 80,
	parameter int SCREEN_ROWS    = 25
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	input  wire ttcw_pkg::req_t request,
	output logic               done,
	output ttcw_pkg::rsp_t     result,
	input  wire logic          cfg_we,
	input  wire logic [7:0]    cfg_wdata
);

	localparam int CELLS  = SCREEN_COLUMNS * SCREEN_ROWS;
	localparam int ADDR_W = $clog2(CELLS);
	localparam int COL_W  = $clog2(SCREEN_COLUMNS);
	localparam int ROW_W  = $clog2(SCREEN_ROWS);
	localparam int CT_W   = $clog2(SCREEN_COLUMNS + ttcw_pkg::TAB_STEP + 1);
	localparam int RT_W   = $clog2(SCREEN_ROWS + 1);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_READ  = 4'b0010,
		ST_SHIFT = 4'b0100,
		ST_FILL  = 4'b1000
	} state_t;

	state_t             state_q;
	logic [ADDR_W-1:0]  cnt_q;
	logic [15:0]        fill_q;
	logic               emit_q;
	logic               scr_q;
	logic               rd_ok_q;
	logic               done_q;
	ttcw_pkg::rsp_t     res_q;
	logic [ROW_W-1:0]   row_q;
	logic [COL_W-1:0]   col_q;
	logic [7:0]         color_q;

	logic               mem_we;
	logic [ADDR_W-1:0]  mem_waddr;
	logic [15:0]        mem_wdata;
	logic [ADDR_W-1:0]  mem_raddr;
	logic [15:0]        mem_rdata;

	logic [CT_W-1:0]    put_col;
	logic [RT_W-1:0]    put_row;
	logic [COL_W-1:0]   put_wcol;
	logic               put_we;
	logic [7:0]         cell_char;
	logic               put_scroll;
	logic [ROW_W-1:0]   new_row;
	logic [COL_W-1:0]   new_col;
	logic [ADDR_W-1:0]  put_addr;
	logic               accept;

	function automatic ttcw_pkg::rsp_t make_rsp(input logic [15:0] data,
			input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col, input logic scr);
		ttcw_pkg::rsp_t r;
		logic [15:0]    row_w;
		logic [15:0]    col_w;
		row_w        = 16'(row);
		col_w        = 16'(col);
		r.read_data  = data;
		r.cursor_row = row_w[4:0];
		r.cursor_col = col_w[6:0];
		r.scrolled   = scr;
		return r;
	endfunction

	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = res_q;

	always_comb begin
		put_col   = CT_W'(col_q);
		put_row   = RT_W'(row_q);
		put_wcol  = col_q;
		put_we    = 1'b0;
		cell_char = ttcw_pkg::CH_BLANK;
		case (request.char_code)
			ttcw_pkg::CH_NEWLINE: begin
				put_col = '0;
				put_row = put_row + RT_W'(1);
			end
			ttcw_pkg::CH_RETURN: begin
				put_col = '0;
			end
			ttcw_pkg::CH_TAB: begin
				put_col = put_col + CT_W'(ttcw_pkg::TAB_STEP);
			end
			ttcw_pkg::CH_BACKSPACE: begin
				if (col_q != '0) begin
					put_col  = put_col - CT_W'(1);
					put_wcol = col_q - COL_W'(1);
					put_we   = 1'b1;
				end
			end
			default: begin
				put_we    = 1'b1;
				cell_char = request.char_code;
				put_col   = put_col + CT_W'(1);
			end
		endcase
		if (put_col >= CT_W'(SCREEN_COLUMNS)) begin
			put_col = '0;
			put_row = put_row + RT_W'(1);
		end
		put_scroll = (put_row >= RT_W'(SCREEN_ROWS));
		new_row    = put_scroll ? ROW_W'(SCREEN_ROWS - 1) : put_row[ROW_W-1:0];
		new_col    = put_col[COL_W-1:0];
		put_addr   = ADDR_W'(32'(row_q) * 32'(SCREEN_COLUMNS) + 32'(put_wcol));
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = put_addr;
		mem_wdata = {color_q, cell_char};
		mem_raddr = ADDR_W'(request.cell_index);
		case (state_q)
			ST_IDLE: begin
				mem_we = accept && (request.req_type == ttcw_pkg::REQ_PUT) && put_we;
			end
			ST_SHIFT: begin
				mem_raddr = cnt_q + ADDR_W'(SCREEN_COLUMNS);
				mem_we    = (cnt_q != '0);
				mem_waddr = cnt_q - ADDR_W'(1);
				mem_wdata = mem_rdata;
			end
			ST_FILL: begin
				mem_we    = 1'b1;
				mem_waddr = cnt_q;
				mem_wdata = fill_q;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_FILL;
			cnt_q   <= '0;
			fill_q  <= ttcw_pkg::RESET_CELL;
			emit_q  <= 1'b0;
			scr_q   <= 1'b0;
			rd_ok_q <= 1'b0;
			done_q  <= 1'b0;
			res_q   <= '0;
			row_q   <= '0;
			col_q   <= '0;
			color_q <= ttcw_pkg::RESET_COLOR;
		end else begin
			done_q <= 1'b0;
			if (cfg_we) begin
				color_q <= cfg_wdata;
			end
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						case (request.req_type)
							ttcw_pkg::REQ_PUT: begin
								row_q <= new_row;
								col_q <= new_col;
								if (put_scroll) begin
									state_q <= ST_SHIFT;
									cnt_q   <= '0;
									fill_q  <= {color_q, ttcw_pkg::CH_BLANK};
									emit_q  <= 1'b1;
									scr_q   <= 1'b1;
								end else begin
									done_q <= 1'b1;
									res_q  <= make_rsp(16'h0000, new_row, new_col, 1'b0);
								end
							end
							ttcw_pkg::REQ_CLEAR: begin
								row_q   <= '0;
								col_q   <= '0;
								state_q <= ST_FILL;
								cnt_q   <= '0;
								fill_q  <= {color_q, ttcw_pkg::CH_BLANK};
								emit_q  <= 1'b1;
								scr_q   <= 1'b0;
							end
							ttcw_pkg::REQ_READ: begin
								rd_ok_q <= (32'(request.cell_index) < 32'(CELLS));
								state_q <= ST_READ;
							end
							default: begin
								done_q <= 1'b1;
								res_q  <= make_rsp(16'h0000, row_q, col_q, 1'b0);
							end
						endcase
					end
				end
				ST_READ: begin
					done_q  <= 1'b1;
					res_q   <= make_rsp(rd_ok_q ? mem_rdata : 16'h0000, row_q, col_q, 1'b0);
					state_q <= ST_IDLE;
				end
				ST_SHIFT: begin
					if (cnt_q == ADDR_W'(CELLS - SCREEN_COLUMNS)) begin
						state_q <= ST_FILL;
					end else begin
						cnt_q <= cnt_q + ADDR_W'(1);
					end
				end
				ST_FILL: begin
					if (cnt_q == ADDR_W'(CELLS - 1)) begin
						state_q <= ST_IDLE;
						emit_q  <= 1'b0;
						if (emit_q) begin
							done_q <= 1'b1;
							res_q  <= make_rsp(16'h0000, row_q, col_q, scr_q);
						end
					end else begin
						cnt_q <= cnt_q + ADDR_W'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	ttcw_screen_ram #(
		.DEPTH  (CELLS),
		.ADDR_W (ADDR_W)
	) u_screen_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

endmodule

`default_nettype wire
